FILE: rtl/rigf_pkg.sv
// ----------------------------------------------------------------------------
// rigf_pkg
// Shared types and constants for the idle-gap packet receive FIFO.
// ----------------------------------------------------------------------------
package rigf_pkg;

  localparam int BYTE_W    = 8;
  localparam int MAXC_W    = 7;
  localparam int GAP_W     = 16;
  localparam int OP_W      = 2;
  localparam int KIND_W    = 2;
  localparam int S_TDATA_W = 16;  // byte_in + max_count, padded to whole bytes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [GAP_W-1:0] IDLE_MAX      = '1;
  localparam logic [GAP_W-1:0] GAP_RESET     = 16'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_GAP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_MODE = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_STORED  = 2'd0,
    KIND_DROPPED = 2'd1,
    KIND_DATA    = 2'd2,
    KIND_EMPTY   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_t;

  // result handed from the controller to the output register
  typedef struct packed {
    logic  load;
    kind_t kind;
    logic  last;
    logic  from_ram;
  } res_t;

endpackage

FILE: rtl/rx_idle_gap_packet_fifo.sv
// ----------------------------------------------------------------------------
// rx_idle_gap_packet_fifo
// Receive ring FIFO that marks packet boundaries by idle time on the line.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser op; tdata byte_in, max_count
//  m_*     | out | m_tvalid/m_tready  | tuser kind; tdata byte_out; tlast last
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
//  Byte and tick items complete when accepted. A read item is accepted, its
//  RAM read is issued in ST_RD_ADDR, and then n <= MAX_READ bytes return one
//  per cycle while not stalled, the single RAM read port setting the pace.
//  A stall on m_tready freezes the burst; the RAM output simply holds.
//  Ticks are taken even while a result waits in the output register.
//  Synchronous reset; no clearing pass, the ring is tracked by fill count.
//
module rx_idle_gap_packet_fifo #(
  parameter int DEPTH    = 256,
  parameter int MAX_READ = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rigf_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] byte_in, [14:8] max_count
  input  logic [rigf_pkg::OP_W-1:0]        s_tuser,   // [1:0] op
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [rigf_pkg::BYTE_W-1:0]      m_tdata,   // [7:0] byte_out
  output logic [rigf_pkg::KIND_W-1:0]      m_tuser,   // [1:0] kind
  output logic                             m_tlast,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rigf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rigf_pkg::CFG_W-1:0]       cfg_data
);

  import rigf_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [GAP_W-1:0]  idle_gap;
  logic              packet_mode;
  logic              out_free;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [BYTE_W-1:0] wr_data, rd_data;
  res_t              res;

  // Configuration registers; written only while the block is quiet (the user's duty, the block does not enforce it).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_gap    <= GAP_RESET;
      packet_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDLE_GAP:    idle_gap    <= cfg_data[GAP_W-1:0];
        CFG_PACKET_MODE: packet_mode <= cfg_data[0];
        default: ;  // unknown register: ignored
      endcase
    end
  end

  // Output register frees up in the same cycle it is taken.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res.load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.load) begin
      m_tuser <= res.kind;
      m_tlast <= res.last;
      m_tdata <= res.from_ram ? rd_data : '0;
    end
  end

  rigf_ctrl #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ),
    .ADDR_W   (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (s_tuser),
    .in_byte     (s_tdata[BYTE_W-1:0]),
    .in_maxc     (s_tdata[BYTE_W+MAXC_W-1:BYTE_W]),
    .out_free    (out_free),
    .idle_gap    (idle_gap),
    .packet_mode (packet_mode),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .res         (res)
  );

  // Ring store: contents undefined until written, reads only reach the
  // filled entries from the read index on, within the fill count.
  rigf_ram #(
    .WIDTH  (BYTE_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

FILE: rtl/rigf_ram.sv
// ----------------------------------------------------------------------------
// rigf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rigf_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/rigf_ctrl.sv
// ----------------------------------------------------------------------------
// rigf_ctrl
// Sequencer: ring pointers, fill and idle counts, read bursts from the RAM.
// ----------------------------------------------------------------------------
module rigf_ctrl #(
  parameter int DEPTH    = 256,
  parameter int MAX_READ = 64,
  parameter int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rigf_pkg::OP_W-1:0]     in_op,
  input  logic [rigf_pkg::BYTE_W-1:0]   in_byte,
  input  logic [rigf_pkg::MAXC_W-1:0]   in_maxc,
  input  logic                          out_free,
  input  logic [rigf_pkg::GAP_W-1:0]    idle_gap,
  input  logic                          packet_mode,
  output logic                          wr_en,
  output logic [ADDR_W-1:0]             wr_addr,
  output logic [rigf_pkg::BYTE_W-1:0]   wr_data,
  output logic                          rd_en,
  output logic [ADDR_W-1:0]             rd_addr,
  output rigf_pkg::res_t                res
);

  import rigf_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = $clog2(MAX_READ + 1);
  localparam int LW = (CW > MAXC_W) ? CW : MAXC_W;

  state_t           state, state_next;
  logic [ADDR_W-1:0] wr_idx, rd_idx;
  logic [CW-1:0]    fill;
  logic [GAP_W-1:0] idle_cnt;
  logic [RW-1:0]    remain;

  op_t              op;
  logic             accept, pkt_ready, full, flush, rd_start, burst_end;
  logic [ADDR_W-1:0] wr_base, wr_idx_inc, rd_idx_inc;
  logic [LW-1:0]    maxc_ext, fill_ext, n_cap, n_full;

  assign op        = op_t'(in_op);
  assign accept    = in_valid && in_ready;
  assign pkt_ready = (fill != '0) && (idle_cnt > idle_gap);
  assign full      = (fill == CW'(DEPTH));
  assign flush     = packet_mode && pkt_ready;
  assign rd_start  = accept && (op == OP_READ) && pkt_ready && (in_maxc != '0);
  assign burst_end = (remain == RW'(1));

  // ring indexes wrap at DEPTH, which need not be a power of two
  assign wr_base    = flush ? '0 : wr_idx;
  assign wr_idx_inc = (wr_base == ADDR_W'(DEPTH - 1)) ? '0 : wr_base + 1'b1;
  assign rd_idx_inc = (rd_idx == ADDR_W'(DEPTH - 1)) ? '0 : rd_idx + 1'b1;

  // burst length: smallest of max_count, MAX_READ and fill
  assign maxc_ext = LW'(in_maxc);
  assign fill_ext = LW'(fill);
  assign n_cap    = (maxc_ext < LW'(MAX_READ)) ? maxc_ext : LW'(MAX_READ);
  assign n_full   = (fill_ext < n_cap) ? fill_ext : n_cap;

  always_comb begin
    in_ready = 1'b0;
    if (state == ST_IDLE) begin
      in_ready = out_free || (op inside {OP_TICK, OP_NONE});
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (rd_start) begin
          state_next = ST_RD_ADDR;
        end
      end
      ST_RD_ADDR: begin
        state_next = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        if (out_free && burst_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs: RAM strobes and result
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_base;
    wr_data = in_byte;
    rd_en   = 1'b0;
    rd_addr = rd_idx;
    res     = '{load: 1'b0, kind: KIND_STORED, last: 1'b1, from_ram: 1'b0};
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_BYTE: begin
              res.load = 1'b1;
              if (full) begin
                res.kind = KIND_DROPPED;
              end else begin
                wr_en    = 1'b1;
                res.kind = KIND_STORED;
              end
            end
            OP_READ: begin
              if (!rd_start) begin
                res.load = 1'b1;
                res.kind = KIND_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD_ADDR: begin
        rd_en = 1'b1;
      end
      ST_RD_DATA: begin
        if (out_free) begin
          res.load     = 1'b1;
          res.kind     = KIND_DATA;
          res.last     = burst_end;
          res.from_ram = 1'b1;
          if (!burst_end) begin
            rd_en   = 1'b1;
            rd_addr = rd_idx_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wr_idx   <= '0;
      rd_idx   <= '0;
      fill     <= '0;
      idle_cnt <= '0;
      remain   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && accept) begin
        case (op)
          OP_BYTE: begin
            if (!full) begin
              wr_idx   <= wr_idx_inc;
              fill     <= (flush ? '0 : fill) + 1'b1;
              idle_cnt <= '0;
              if (flush) begin
                rd_idx <= '0;
              end
            end
          end
          OP_TICK: begin
            if (idle_cnt != IDLE_MAX) begin
              idle_cnt <= idle_cnt + 1'b1;
            end
          end
          OP_READ: begin
            if (rd_start) begin
              remain <= n_full[RW-1:0];
            end
          end
          default: ;
        endcase
      end
      if (state == ST_RD_DATA && out_free) begin
        rd_idx <= rd_idx_inc;
        fill   <= fill - 1'b1;
        remain <= remain - 1'b1;
      end
    end
  end

  // ---- assertions ----
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("RAM read and write in one cycle");

  a_burst_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD_DATA) |-> (remain != '0))
    else $error("read burst with nothing left");

  a_data_has_fill: assert property (@(posedge clk) disable iff (rst)
    (res.load && res.from_ram) |-> (fill != '0))
    else $error("data item from an empty ring");

  a_rd_addr_then_data: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD_ADDR) |=> (state == ST_RD_DATA))
    else $error("read data phase skipped");

endmodule
